/* rtl/core/u8dv_pkg.sv */
// shared types, constants and decode helpers for the utf-8 stream decoder
`timescale 1ns / 1ps

package u8dv_pkg;

  localparam int OffsetBits = 16;
  localparam int CpBits     = 31;
  localparam int FifoDepth  = 4;
  localparam int FifoPtrW   = $clog2(FifoDepth);

  localparam logic [OffsetBits-1:0] OfsMax = {OffsetBits{1'b1}};

  localparam logic [7:0] LeadMask2 = 8'he0;
  localparam logic [7:0] LeadMask3 = 8'hf0;
  localparam logic [7:0] LeadMask4 = 8'hf8;
  localparam logic [7:0] LeadMask5 = 8'hfc;
  localparam logic [7:0] LeadMask6 = 8'hfe;
  localparam logic [7:0] ContMask  = 8'hc0;
  localparam logic [7:0] ContTag   = 8'h80;

  typedef enum logic [1:0] {
    KIND_CHAR        = 2'd0,
    KIND_END_VALID   = 2'd1,
    KIND_END_INVALID = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CAUSE_NONE      = 2'd0,
    CAUSE_BAD_LEAD  = 2'd1,
    CAUSE_BAD_CONT  = 2'd2,
    CAUSE_TRUNCATED = 2'd3
  } cause_e;

  typedef struct packed {
    kind_e                 kind;
    logic [CpBits-1:0]     code_point;
    cause_e                error_cause;
    logic [OffsetBits-1:0] end_offset;
    logic                  run_last;
  } result_t;

  // character length from its lead byte, zero for a bad lead
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    if (c[7] == 1'b0) begin
      len = 3'd1;
    end else if ((c & LeadMask2) == 8'hc0) begin
      len = 3'd2;
    end else if ((c & LeadMask3) == 8'he0) begin
      len = 3'd3;
    end else if ((c & LeadMask4) == 8'hf0) begin
      len = 3'd4;
    end else if ((c & LeadMask5) == 8'hf8) begin
      len = 3'd5;
    end else if ((c & LeadMask6) == 8'hfc) begin
      len = 3'd6;
    end
    return len;
  endfunction

  // payload bits of a lead byte of the given length
  function automatic logic [6:0] lead_payload(input logic [7:0] c, input logic [2:0] len);
    logic [6:0] p;
    p = 7'd0;
    case (len)
      3'd1:    p = c[6:0];
      3'd2:    p = {2'b00, c[4:0]};
      3'd3:    p = {3'b000, c[3:0]};
      3'd4:    p = {4'b0000, c[2:0]};
      3'd5:    p = {5'b00000, c[1:0]};
      3'd6:    p = {6'b000000, c[0]};
      default: p = 7'd0;
    endcase
    return p;
  endfunction

  function automatic result_t mk_end(input kind_e k, input cause_e cause,
                                     input logic [OffsetBits-1:0] ofs);
    result_t r;
    r             = '0;
    r.kind        = k;
    r.error_cause = cause;
    r.end_offset  = ofs;
    return r;
  endfunction

  function automatic result_t mk_char(input logic [CpBits-1:0] cp);
    result_t r;
    r            = '0;
    r.kind       = KIND_CHAR;
    r.code_point = cp;
    return r;
  endfunction

endpackage

/* rtl/core/u8dv_if.sv */
// valid/ready channel interfaces for input bytes and decode results
`timescale 1ns / 1ps

interface u8dv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       buffer_last;

  modport source (output valid, output data_byte, output buffer_last, input ready);
  modport sink   (input valid, input data_byte, input buffer_last, output ready);
endinterface

interface u8dv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [30:0] code_point;
  logic [1:0]  error_cause;
  logic [15:0] end_offset;
  logic        run_last;

  modport source (output valid, output kind, output code_point, output error_cause,
                  output end_offset, output run_last, input ready);
  modport sink   (input valid, input kind, input code_point, input error_cause,
                  input end_offset, input run_last, output ready);
endinterface

/* rtl/core/u8dv_decode.sv */
// decoder state and per-byte result logic
`timescale 1ns / 1ps

module u8dv_decode
  import u8dv_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic [7:0]  byte_i,
  input  logic        last_i,
  output result_t     res0_o,
  output result_t     res1_o,
  output logic [1:0]  cnt_o
);

  logic [CpBits-1:0]     acc_q, acc_d;
  logic [2:0]            exp_q, exp_d;
  logic [2:0]            seen_q, seen_d;
  logic [OffsetBits-1:0] ofs_q, ofs_d;
  logic [OffsetBits-1:0] lead_q, lead_d;
  logic                  fin_q, fin_d;

  logic [OffsetBits-1:0] nxt_ofs;
  logic [2:0]            len;
  logic [CpBits-1:0]     acc_new;
  logic [2:0]            seen_new;
  result_t               r0, r1;
  logic [1:0]            n;

  assign nxt_ofs  = (ofs_q == OfsMax) ? OfsMax : ofs_q + 1'b1;
  assign len      = lead_len(byte_i);
  assign acc_new  = {acc_q[CpBits-7:0], byte_i[5:0]};
  assign seen_new = seen_q + 3'd1;

  always_comb begin
    acc_d  = acc_q;
    exp_d  = exp_q;
    seen_d = seen_q;
    ofs_d  = ofs_q;
    lead_d = lead_q;
    fin_d  = fin_q;
    r0     = '0;
    r1     = '0;
    n      = 2'd0;
    if (step_i) begin
      if (!fin_q) begin
        if (exp_q == 3'd0) begin
          if (byte_i == 8'd0) begin
            r0    = mk_end(KIND_END_VALID, CAUSE_NONE, ofs_q);
            n     = 2'd1;
            fin_d = 1'b1;
          end else if (len == 3'd0) begin
            r0    = mk_end(KIND_END_INVALID, CAUSE_BAD_LEAD, ofs_q);
            n     = 2'd1;
            fin_d = 1'b1;
          end else if (len == 3'd1) begin
            r0 = mk_char({{(CpBits-8){1'b0}}, byte_i});
            n  = 2'd1;
            if (last_i) begin
              r1 = mk_end(KIND_END_VALID, CAUSE_NONE, nxt_ofs);
              n  = 2'd2;
            end
          end else if (last_i) begin
            r0    = mk_end(KIND_END_INVALID, CAUSE_TRUNCATED, ofs_q);
            n     = 2'd1;
            fin_d = 1'b1;
          end else begin
            acc_d  = {{(CpBits-7){1'b0}}, lead_payload(byte_i, len)};
            exp_d  = len;
            seen_d = 3'd1;
            lead_d = ofs_q;
          end
        end else if (last_i && (({1'b0, seen_q} + 4'd1) < {1'b0, exp_q})) begin
          r0    = mk_end(KIND_END_INVALID, CAUSE_TRUNCATED, lead_q);
          n     = 2'd1;
          fin_d = 1'b1;
        end else if ((byte_i & ContMask) != ContTag) begin
          r0    = mk_end(KIND_END_INVALID, CAUSE_BAD_CONT, lead_q);
          n     = 2'd1;
          fin_d = 1'b1;
        end else if (seen_new >= exp_q) begin
          r0     = mk_char(acc_new);
          n      = 2'd1;
          acc_d  = '0;
          exp_d  = 3'd0;
          seen_d = 3'd0;
          if (last_i) begin
            r1 = mk_end(KIND_END_VALID, CAUSE_NONE, nxt_ofs);
            n  = 2'd2;
          end
        end else begin
          acc_d  = acc_new;
          seen_d = seen_new;
        end
      end
      ofs_d = nxt_ofs;
      if (last_i) begin
        acc_d  = '0;
        exp_d  = 3'd0;
        seen_d = 3'd0;
        ofs_d  = '0;
        lead_d = '0;
        fin_d  = 1'b0;
      end
    end
  end

  always_comb begin
    res0_o = r0;
    res1_o = r1;
    if (n == 2'd1) begin
      res0_o.run_last = 1'b1;
    end
    if (n == 2'd2) begin
      res1_o.run_last = 1'b1;
    end
  end

  assign cnt_o = n;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      exp_q  <= '0;
      seen_q <= '0;
      ofs_q  <= '0;
      lead_q <= '0;
      fin_q  <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      exp_q  <= exp_d;
      seen_q <= seen_d;
      ofs_q  <= ofs_d;
      lead_q <= lead_d;
      fin_q  <= fin_d;
    end
  end

endmodule

/* rtl/core/u8dv_result_fifo.sv */
// small result queue, up to two writes and one read per cycle
`timescale 1ns / 1ps

module u8dv_result_fifo
  import u8dv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] push_cnt_i,
  input  result_t    push0_i,
  input  result_t    push1_i,
  output logic       space_o,
  output logic       valid_o,
  input  logic       pop_i,
  output result_t    head_o
);

  result_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [FifoPtrW:0]     cnt_q, cnt_d;
  logic                  pop;
  logic [FifoPtrW-1:0]   wr_nxt;

  assign valid_o = (cnt_q != '0);
  assign pop     = pop_i && valid_o;
  assign space_o = (cnt_q <= (FifoPtrW + 1)'(FifoDepth - 2));
  assign head_o  = mem_q[rd_q];
  assign wr_nxt  = wr_q + 1'b1;

  always_comb begin
    wr_d  = wr_q + FifoPtrW'(push_cnt_i);
    rd_d  = pop ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (FifoPtrW + 1)'(push_cnt_i) - (FifoPtrW + 1)'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_cnt_i != 2'd0) begin
      mem_q[wr_q] <= push0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_q[wr_nxt] <= push1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

/* rtl/core/utf8_stream_decode_validate.sv */
// top level of the utf-8 stream decoder and validator
`timescale 1ns / 1ps

// Takes one byte of UTF-8 text per beat (old 1-to-6-byte form) and gives one
// result beat per finished character, plus an end beat when the string ends
// (zero byte, error, or buffer end); a byte may cause up to two result beats.
// A byte accepted into the input register waits there until the result queue
// has room for two results, is then decoded against the character state and
// written into a four-entry result queue, from which its first result is
// offered on the output.
// The block takes one byte per cycle as long as the queue has room for two
// results; a sink that takes one beat per cycle keeps that rate except where
// a byte produces two results, which then wait their turn in the queue.

module utf8_stream_decode_validate
  import u8dv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  u8dv_in_if.sink    in_i,
  u8dv_out_if.source out_o
);

  logic       vld_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       space;
  logic       adv;
  logic       load;
  result_t    res0, res1, head;
  logic [1:0] cnt;

  assign adv        = vld_q && space;
  assign in_i.ready = !vld_q || adv;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_i.ready) begin
      vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= in_i.data_byte;
      last_q <= in_i.buffer_last;
    end
  end

  u8dv_decode i_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (adv),
    .byte_i (byte_q),
    .last_i (last_q),
    .res0_o (res0),
    .res1_o (res1),
    .cnt_o  (cnt)
  );

  u8dv_result_fifo i_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_cnt_i (cnt),
    .push0_i    (res0),
    .push1_i    (res1),
    .space_o    (space),
    .valid_o    (out_o.valid),
    .pop_i      (out_o.ready),
    .head_o     (head)
  );

  assign out_o.kind        = head.kind;
  assign out_o.code_point  = head.code_point;
  assign out_o.error_cause = head.error_cause;
  assign out_o.end_offset  = head.end_offset;
  assign out_o.run_last    = head.run_last;

endmodule

/* rtl/core/u8dv_checker.sv */
// port-level checks on the utf-8 decoder, bound to the top level
`timescale 1ns / 1ps

module u8dv_checker
  import u8dv_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [1:0]  kind_i,
  input logic [30:0] code_point_i,
  input logic [1:0]  error_cause_i,
  input logic [15:0] end_offset_i,
  input logic        run_last_i
);

  // a stalled result beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
      $stable(code_point_i) && $stable(error_cause_i) && $stable(end_offset_i))
    else $error("stalled result beat changed");

  // character beats carry no cause and no offset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_CHAR) |->
      (error_cause_i == CAUSE_NONE) && (end_offset_i == '0))
    else $error("character beat with end fields set");

  // end beats carry no code point and close the byte's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i != KIND_CHAR) |-> (code_point_i == '0) && run_last_i)
    else $error("end beat malformed");

  // only an invalid end has a cause
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == KIND_END_VALID) |-> (error_cause_i == CAUSE_NONE))
    else $error("valid end with cause");

endmodule

bind utf8_stream_decode_validate u8dv_checker i_u8dv_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .code_point_i  (out_o.code_point),
  .error_cause_i (out_o.error_cause),
  .end_offset_i  (out_o.end_offset),
  .run_last_i    (out_o.run_last)
);

/* sim/utf8_stream_decode_validate_tb.sv */
// self-checking testbench for the utf-8 stream decoder and validator
`timescale 1ns / 1ps

module utf8_stream_decode_validate_tb;
  import u8dv_pkg::*;

  localparam int ResetCycles   = 6;
  localparam int ItemTarget    = 1450;
  localparam int QuietFrom     = 1250;
  localparam int WatchdogLimit = 1000;
  localparam int DrainCycles   = 20;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_ONE,
    ROW_NONE
  } row_e;

  typedef struct {
    logic [7:0] data;
    logic       last;
    row_e       how;
    result_t    want;
  } row_t;

  logic clk_i;
  logic rst_ni;

  u8dv_in_if  in_bus ();
  u8dv_out_if out_bus ();

  utf8_stream_decode_validate dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  // decoder state mirrored in the testbench by decode_byte
  logic [CpBits-1:0]     cp_acc;
  int                    chr_len;
  int                    chr_got;
  logic [OffsetBits-1:0] byte_pos;
  logic [OffsetBits-1:0] lead_pos;
  logic                  str_done;

  result_t    pending_results[$];
  row_t       directed_rows[$];
  logic [7:0] text_q[$];

  row_e    row_how;
  result_t row_want;
  int      in_taken;
  int      idle_cycles;
  int      errors;
  logic    quiet;
  logic    tx_idle;
  logic    rx_idle;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic result_t make_res(input kind_e k, input logic [CpBits-1:0] cp,
                                       input cause_e cause,
                                       input logic [OffsetBits-1:0] ofs);
    result_t r;
    r.kind        = k;
    r.code_point  = cp;
    r.error_cause = cause;
    r.end_offset  = ofs;
    r.run_last    = 1'b0;
    return r;
  endfunction

  task automatic flag(input string what, input logic [31:0] want_v, input logic [31:0] got_v);
    errors++;
    $error("%s: expected %0h, got %0h", what, want_v, got_v);
  endtask

  task automatic decode_byte(input logic [7:0] c, input logic last, input row_e how,
                             input result_t typed_res);
    result_t               res[2];
    int                    n;
    int                    len;
    logic [6:0]            msk;
    logic [OffsetBits-1:0] here;
    logic [OffsetBits-1:0] nxt;
    here = byte_pos;
    nxt  = (byte_pos == OfsMax) ? byte_pos : byte_pos + 1'b1;
    n    = 0;
    if (!str_done) begin
      if (chr_len == 0) begin
        casez (c)
          8'b0???????: begin len = 1; msk = 7'h7f; end
          8'b110?????: begin len = 2; msk = 7'h1f; end
          8'b1110????: begin len = 3; msk = 7'h0f; end
          8'b11110???: begin len = 4; msk = 7'h07; end
          8'b111110??: begin len = 5; msk = 7'h03; end
          8'b1111110?: begin len = 6; msk = 7'h01; end
          default:     begin len = 0; msk = 7'h00; end
        endcase
        if (c == 8'h00) begin
          res[n++] = make_res(KIND_END_VALID, '0, CAUSE_NONE, here);
          str_done = 1'b1;
        end else if (len == 0) begin
          res[n++] = make_res(KIND_END_INVALID, '0, CAUSE_BAD_LEAD, here);
          str_done = 1'b1;
        end else if (len == 1) begin
          res[n++] = make_res(KIND_CHAR, CpBits'(c), CAUSE_NONE, '0);
          if (last) begin
            res[n++] = make_res(KIND_END_VALID, '0, CAUSE_NONE, nxt);
          end
        end else if (last) begin
          res[n++] = make_res(KIND_END_INVALID, '0, CAUSE_TRUNCATED, here);
          str_done = 1'b1;
        end else begin
          cp_acc   = CpBits'(c[6:0] & msk);
          chr_len  = len;
          chr_got  = 1;
          lead_pos = here;
        end
      end else if (last && chr_got + 1 < chr_len) begin
        res[n++] = make_res(KIND_END_INVALID, '0, CAUSE_TRUNCATED, lead_pos);
        str_done = 1'b1;
      end else if ((c & ContMask) != ContTag) begin
        res[n++] = make_res(KIND_END_INVALID, '0, CAUSE_BAD_CONT, lead_pos);
        str_done = 1'b1;
      end else begin
        cp_acc = {cp_acc[CpBits-7:0], c[5:0]};
        chr_got++;
        if (chr_got >= chr_len) begin
          res[n++] = make_res(KIND_CHAR, cp_acc, CAUSE_NONE, '0);
          chr_len = 0;
          chr_got = 0;
          cp_acc  = '0;
          if (last) begin
            res[n++] = make_res(KIND_END_VALID, '0, CAUSE_NONE, nxt);
          end
        end
      end
    end
    byte_pos = nxt;
    if (n > 0) begin
      res[n-1].run_last = 1'b1;
    end
    if (last) begin
      cp_acc   = '0;
      chr_len  = 0;
      chr_got  = 0;
      byte_pos = '0;
      lead_pos = '0;
      str_done = 1'b0;
    end
    case (how)
      ROW_PREDICT: begin
        for (int i = 0; i < n; i++) begin
          pending_results.push_back(res[i]);
        end
      end
      ROW_ONE: pending_results.push_back(typed_res);
      default: ;
    endcase
  endtask

  always @(posedge clk_i) begin : monitor
    result_t got;
    result_t want;
    logic    took;
    took = 1'b0;
    if (rst_ni) begin
      if (out_bus.valid && out_bus.ready) begin
        took = 1'b1;
        got = make_res(kind_e'(out_bus.kind), out_bus.code_point,
                       cause_e'(out_bus.error_cause), out_bus.end_offset);
        got.run_last = out_bus.run_last;
        if (pending_results.size() == 0) begin
          flag("unexpected result, kind", '0, got.kind);
        end else begin
          want = pending_results.pop_front();
          if (got.kind !== want.kind) flag("kind", want.kind, got.kind);
          if (got.code_point !== want.code_point) begin
            flag("code_point", want.code_point, got.code_point);
          end
          if (got.error_cause !== want.error_cause) begin
            flag("error_cause", want.error_cause, got.error_cause);
          end
          if (got.end_offset !== want.end_offset) begin
            flag("end_offset", want.end_offset, got.end_offset);
          end
          if (got.run_last !== want.run_last) flag("run_last", want.run_last, got.run_last);
        end
      end
      if (in_bus.valid && in_bus.ready) begin
        took = 1'b1;
        decode_byte(in_bus.data_byte, in_bus.buffer_last, row_how, row_want);
        in_taken++;
      end
      idle_cycles = took ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < WatchdogLimit) @(posedge clk_i);
    $display("FAILURE");
    $finish;
  end

  // result sink with random stall bursts
  initial begin
    int hold;
    hold          = 0;
    rx_idle       = 1'b0;
    out_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (quiet) begin
        out_bus.ready = 1'b1;
      end else if (hold > 0) begin
        hold--;
      end else begin
        if ($urandom_range(0, 15) == 0) rx_idle = ~rx_idle;
        out_bus.ready = !(rx_idle && $urandom_range(0, 2) == 0);
        hold = $urandom_range(1, 16) - 1;
      end
    end
  end

  function automatic logic [7:0] lead_byte(input int len);
    logic [7:0] b;
    case (len)
      1:       b = 8'($urandom_range(1, 127));
      2:       b = 8'hc0 | 8'($urandom_range(0, 31));
      3:       b = 8'he0 | 8'($urandom_range(0, 15));
      4:       b = 8'hf0 | 8'($urandom_range(0, 7));
      5:       b = 8'hf8 | 8'($urandom_range(0, 3));
      default: b = 8'hfc | 8'($urandom_range(0, 1));
    endcase
    return b;
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // mostly well-formed text with some broken characters, noise and early ends
  task automatic make_buffer();
    int nch;
    int len;
    int kept;
    int pick;
    text_q.delete();
    nch = $urandom_range(1, 10);
    for (int i = 0; i < nch; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        len = $urandom_range(1, 6);
        text_q.push_back(lead_byte(len));
        repeat (len - 1) text_q.push_back(cont_byte());
      end else if (pick < 80) begin
        len = $urandom_range(2, 6);
        kept = $urandom_range(0, len - 2);
        text_q.push_back(lead_byte(len));
        repeat (kept) text_q.push_back(cont_byte());
        text_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 86) begin
        text_q.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 90) begin
        text_q.push_back(8'h00);
      end else begin
        len = $urandom_range(2, 6);
        kept = $urandom_range(0, len - 2);
        text_q.push_back(lead_byte(len));
        repeat (kept) text_q.push_back(cont_byte());
        break;
      end
    end
  endtask

  task automatic add_row(input logic [7:0] d, input logic last, input row_e how,
                         input result_t want);
    row_t r;
    r.data          = d;
    r.last          = last;
    r.how           = how;
    r.want          = want;
    r.want.run_last = 1'b1;
    directed_rows.push_back(r);
  endtask

  task automatic send_byte(input logic [7:0] d, input logic last, input row_e how,
                           input result_t want);
    int seen;
    if (!quiet && tx_idle && $urandom_range(0, 5) == 0) begin
      in_bus.valid = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    row_how            = how;
    row_want           = want;
    in_bus.data_byte   = d;
    in_bus.buffer_last = last;
    in_bus.valid       = 1'b1;
    seen               = in_taken;
    do @(negedge clk_i); while (in_taken == seen);
  endtask

  task automatic wait_drained();
    in_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_bus.valid       = 1'b0;
    in_bus.data_byte   = '0;
    in_bus.buffer_last = 1'b0;
    cp_acc             = '0;
    chr_len            = 0;
    chr_got            = 0;
    byte_pos           = '0;
    lead_pos           = '0;
    str_done           = 1'b0;
    row_how            = ROW_PREDICT;
    row_want           = '0;
    in_taken           = 0;
    idle_cycles        = 0;
    errors             = 0;
    quiet              = 1'b0;
    tx_idle            = 1'b1;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;

    // ascii, zero byte end, ignored tail
    add_row(8'h41, 1'b0, ROW_ONE, make_res(KIND_CHAR, 31'h41, CAUSE_NONE, '0));
    add_row(8'h00, 1'b0, ROW_ONE, make_res(KIND_END_VALID, '0, CAUSE_NONE, 16'd1));
    add_row(8'h55, 1'b1, ROW_NONE, '0);
    // two, three and six byte forms, clean buffer end
    add_row(8'hc3, 1'b0, ROW_PREDICT, '0);
    add_row(8'ha9, 1'b0, ROW_PREDICT, '0);
    add_row(8'he2, 1'b0, ROW_PREDICT, '0);
    add_row(8'h82, 1'b0, ROW_PREDICT, '0);
    add_row(8'hac, 1'b0, ROW_PREDICT, '0);
    add_row(8'hfd, 1'b0, ROW_PREDICT, '0);
    repeat (4) add_row(8'hbf, 1'b0, ROW_PREDICT, '0);
    add_row(8'hbf, 1'b0, ROW_ONE, make_res(KIND_CHAR, 31'h7fffffff, CAUSE_NONE, '0));
    add_row(8'h7f, 1'b1, ROW_PREDICT, '0);
    // bad lead
    add_row(8'hff, 1'b0, ROW_ONE, make_res(KIND_END_INVALID, '0, CAUSE_BAD_LEAD, '0));
    add_row(8'h80, 1'b1, ROW_NONE, '0);
    // bad continuation
    add_row(8'hc0, 1'b0, ROW_PREDICT, '0);
    add_row(8'h41, 1'b0, ROW_ONE, make_res(KIND_END_INVALID, '0, CAUSE_BAD_CONT, '0));
    add_row(8'h00, 1'b1, ROW_NONE, '0);
    // buffer ends inside a character, last byte not a continuation
    add_row(8'he0, 1'b0, ROW_PREDICT, '0);
    add_row(8'h41, 1'b1, ROW_ONE, make_res(KIND_END_INVALID, '0, CAUSE_TRUNCATED, '0));
    // buffer ends on a lead byte
    add_row(8'hfc, 1'b1, ROW_ONE, make_res(KIND_END_INVALID, '0, CAUSE_TRUNCATED, '0));
    add_row(8'h00, 1'b1, ROW_ONE, make_res(KIND_END_VALID, '0, CAUSE_NONE, '0));

    foreach (directed_rows[i]) begin
      send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].how,
                directed_rows[i].want);
    end
    wait_drained();

    while (in_taken < ItemTarget) begin
      quiet   = (in_taken >= QuietFrom);
      tx_idle = ($urandom_range(0, 2) != 0);
      make_buffer();
      foreach (text_q[i]) begin
        send_byte(text_q[i], i == text_q.size() - 1, ROW_PREDICT, '0);
      end
      if ($urandom_range(0, 29) == 0) wait_drained();
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
